### design/obb_pair_separating_axis_test_unit_defines.svh
// Assertion macros shared by the OBB pair separating-axis checker.
`ifndef OBB_PAIR_SEPARATING_AXIS_TEST_UNIT_DEFINES_SVH
`define OBB_PAIR_SEPARATING_AXIS_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBBSAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obbsat: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OBBSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obbsat: next-cycle check failed");

`endif

### design/obbsat_pkg.sv
// Shared widths, pipeline stage indexes and control struct for the OBB SAT unit.
package obbsat_pkg;

    localparam int COORD_WIDTH    = 24;
    localparam int AXIS_FRAC_BITS = 14;
    localparam int AXIS_WIDTH     = 16;

    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    // up vector needs one more bit: negating -32768
    localparam int DIR_WIDTH   = AXIS_WIDTH + 1;
    localparam int DPROD_WIDTH = DIFF_WIDTH + DIR_WIDTH;
    localparam int DSUM_WIDTH  = DPROD_WIDTH + 1;
    localparam int APROD_WIDTH = AXIS_WIDTH + DIR_WIDTH;
    localparam int ASUM_WIDTH  = APROD_WIDTH + 1;
    localparam int TERM_WIDTH  = SIZE_WIDTH + ASUM_WIDTH;
    localparam int SOWN_WIDTH  = SIZE_WIDTH + 2 * AXIS_FRAC_BITS;
    localparam int RHS_WIDTH   = ((TERM_WIDTH > SOWN_WIDTH) ? TERM_WIDTH : SOWN_WIDTH) + 2;
    localparam int LHS_WIDTH   = DSUM_WIDTH + AXIS_FRAC_BITS + 1;
    localparam int CMP_WIDTH   = (LHS_WIDTH > RHS_WIDTH) ? LHS_WIDTH : RHS_WIDTH;

    localparam int NUM_AXES = 4;

    // pipeline stage indexes
    localparam int NUM_STAGES = 6;
    localparam int ST_OFFSET  = 0;
    localparam int ST_PROD    = 1;
    localparam int ST_DOT     = 2;
    localparam int ST_SCALE   = 3;
    localparam int ST_CMP     = 4;
    localparam int ST_OUT     = 5;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

### design/obbsat_pipe_ctrl.sv
// Valid bits and per-stage load enables of the OBB SAT pipeline.
module obbsat_pipe_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_stall,
    output logic                   o_stall,
    output obbsat_pkg::t_pipe_ctl  o_ctl
);

    localparam int NS = obbsat_pkg::NUM_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_en;

    // a stage loads when empty or when its content moves on
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall   = !w_en[0];
    assign o_ctl.en  = w_en;
    assign o_ctl.vld = r_vld;

endmodule

### design/obbsat_axis_unit.sv
// One separating-axis test: projections, extents and compare over four stages.
module obbsat_axis_unit (
    input  logic                                        i_clk,
    input  obbsat_pkg::t_pipe_ctl                       i_ctl,
    input  logic signed [obbsat_pkg::DIFF_WIDTH-1:0]    i_dx,
    input  logic signed [obbsat_pkg::DIFF_WIDTH-1:0]    i_dy,
    input  logic signed [obbsat_pkg::DIR_WIDTH-1:0]     i_dir_x,
    input  logic signed [obbsat_pkg::DIR_WIDTH-1:0]     i_dir_y,
    input  logic signed [obbsat_pkg::AXIS_WIDTH-1:0]    i_oth_rx,
    input  logic signed [obbsat_pkg::AXIS_WIDTH-1:0]    i_oth_ry,
    input  logic        [obbsat_pkg::SIZE_WIDTH-1:0]    i_oth_w,
    input  logic        [obbsat_pkg::SIZE_WIDTH-1:0]    i_oth_h,
    input  logic        [obbsat_pkg::SIZE_WIDTH-1:0]    i_own_size,
    output logic                                        o_sep
);

    localparam int SW   = obbsat_pkg::SIZE_WIDTH;
    localparam int DPW  = obbsat_pkg::DPROD_WIDTH;
    localparam int DSW  = obbsat_pkg::DSUM_WIDTH;
    localparam int APW  = obbsat_pkg::APROD_WIDTH;
    localparam int ASW  = obbsat_pkg::ASUM_WIDTH;
    localparam int TW   = obbsat_pkg::TERM_WIDTH;
    localparam int CMPW = obbsat_pkg::CMP_WIDTH;
    localparam int LSH  = obbsat_pkg::AXIS_FRAC_BITS + 1;
    localparam int SSH  = 2 * obbsat_pkg::AXIS_FRAC_BITS;

    // products
    logic signed [DPW-1:0] r_pdx, r_pdy;
    logic signed [APW-1:0] r_prx_a, r_pry_b, r_prx_b, r_pry_a;
    logic        [SW-1:0]  r_p_own, r_p_w, r_p_h;

    // absolute dot products
    logic signed [DSW-1:0] n_dsum;
    logic signed [ASW-1:0] n_rsum, n_usum;
    logic        [DSW-1:0] r_dabs;
    logic        [ASW-1:0] r_rabs, r_uabs;
    logic        [SW-1:0]  r_d_own, r_d_w, r_d_h;

    // scaled extents
    logic        [DSW-1:0] r_s_dabs;
    logic        [TW-1:0]  r_th, r_tw;
    logic        [SW-1:0]  r_s_own;

    logic        [CMPW-1:0] n_lhs, n_rhs;
    logic                   r_sep;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[obbsat_pkg::ST_PROD]) begin
            r_pdx   <= i_dx * i_dir_x;
            r_pdy   <= i_dy * i_dir_y;
            r_prx_a <= i_oth_rx * i_dir_x;
            r_pry_b <= i_oth_ry * i_dir_y;
            r_prx_b <= i_oth_rx * i_dir_y;
            r_pry_a <= i_oth_ry * i_dir_x;
            r_p_own <= i_own_size;
            r_p_w   <= i_oth_w;
            r_p_h   <= i_oth_h;
        end
    end

    always_comb begin
        n_dsum = DSW'(r_pdx) + DSW'(r_pdy);
        n_rsum = ASW'(r_prx_a) + ASW'(r_pry_b);
        n_usum = ASW'(r_prx_b) - ASW'(r_pry_a);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[obbsat_pkg::ST_DOT]) begin
            r_dabs  <= n_dsum[DSW-1] ? DSW'(-n_dsum) : DSW'(n_dsum);
            r_rabs  <= n_rsum[ASW-1] ? ASW'(-n_rsum) : ASW'(n_rsum);
            r_uabs  <= n_usum[ASW-1] ? ASW'(-n_usum) : ASW'(n_usum);
            r_d_own <= r_p_own;
            r_d_w   <= r_p_w;
            r_d_h   <= r_p_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[obbsat_pkg::ST_SCALE]) begin
            r_th     <= r_d_h * r_uabs;
            r_tw     <= r_d_w * r_rabs;
            r_s_dabs <= r_dabs;
            r_s_own  <= r_d_own;
        end
    end

    // 2*|d.a| vs extents, all at 2^(2*frac) scale
    always_comb begin
        n_lhs = CMPW'({r_s_dabs, {LSH{1'b0}}});
        n_rhs = CMPW'(r_th) + CMPW'(r_tw) + (CMPW'(r_s_own) << SSH);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[obbsat_pkg::ST_CMP]) begin
            r_sep <= n_lhs > n_rhs;
        end
    end

    assign o_sep = r_sep;

endmodule

### design/obb_pair_separating_axis_test_unit.sv
// Top level: 2-D oriented box pair collision test by separating axes.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  input   | in        | i_valid / o_stall  | two boxes: center, right vector, w, h
//  output  | out       | o_valid / i_stall  | o_collided
//
// One pair enters per cycle while o_stall is low; a pair passes the offset,
// products, dot/abs, extent multiply, compare and output stages in turn.
// The extent multiplies (size x dot) set the stage depth.
// Synchronous active-low reset clears only the valid bits.
// Each stage holds while the next one is full and cannot move, so bubbles
// collapse and an input transfer is refused only when all six stages are full.
module obb_pair_separating_axis_test_unit (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic signed [obbsat_pkg::COORD_WIDTH-1:0]  i_first_center_x,
    input  logic signed [obbsat_pkg::COORD_WIDTH-1:0]  i_first_center_y,
    input  logic signed [obbsat_pkg::AXIS_WIDTH-1:0]   i_first_axis_x,
    input  logic signed [obbsat_pkg::AXIS_WIDTH-1:0]   i_first_axis_y,
    input  logic        [obbsat_pkg::SIZE_WIDTH-1:0]   i_first_width,
    input  logic        [obbsat_pkg::SIZE_WIDTH-1:0]   i_first_height,
    input  logic signed [obbsat_pkg::COORD_WIDTH-1:0]  i_second_center_x,
    input  logic signed [obbsat_pkg::COORD_WIDTH-1:0]  i_second_center_y,
    input  logic signed [obbsat_pkg::AXIS_WIDTH-1:0]   i_second_axis_x,
    input  logic signed [obbsat_pkg::AXIS_WIDTH-1:0]   i_second_axis_y,
    input  logic        [obbsat_pkg::SIZE_WIDTH-1:0]   i_second_width,
    input  logic        [obbsat_pkg::SIZE_WIDTH-1:0]   i_second_height,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic                                       o_collided
);

    localparam int DW  = obbsat_pkg::DIFF_WIDTH;
    localparam int DRW = obbsat_pkg::DIR_WIDTH;
    localparam int AW  = obbsat_pkg::AXIS_WIDTH;
    localparam int SW  = obbsat_pkg::SIZE_WIDTH;
    localparam int NA  = obbsat_pkg::NUM_AXES;

    obbsat_pkg::t_pipe_ctl w_ctl;

    // offset stage registers; box index 0 = first, 1 = second
    logic signed [DW-1:0]  r_dx, r_dy;
    logic signed [DRW-1:0] r_dir_x [NA];
    logic signed [DRW-1:0] r_dir_y [NA];
    logic        [SW-1:0]  r_own   [NA];
    logic signed [AW-1:0]  r_rx    [2];
    logic signed [AW-1:0]  r_ry    [2];
    logic        [SW-1:0]  r_w     [2];
    logic        [SW-1:0]  r_h     [2];

    logic [NA-1:0] w_sep;
    logic          r_collided;

    obbsat_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_ctl   (w_ctl)
    );

    // Axes in order: first up (-ry, rx), first right, second up, second right.
    // Own size of an up axis is the height, of a right axis the width.
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[obbsat_pkg::ST_OFFSET]) begin
            r_dx <= DW'(i_second_center_x) - DW'(i_first_center_x);
            r_dy <= DW'(i_second_center_y) - DW'(i_first_center_y);

            r_dir_x[0] <= -DRW'(i_first_axis_y);
            r_dir_y[0] <= DRW'(i_first_axis_x);
            r_dir_x[1] <= DRW'(i_first_axis_x);
            r_dir_y[1] <= DRW'(i_first_axis_y);
            r_dir_x[2] <= -DRW'(i_second_axis_y);
            r_dir_y[2] <= DRW'(i_second_axis_x);
            r_dir_x[3] <= DRW'(i_second_axis_x);
            r_dir_y[3] <= DRW'(i_second_axis_y);

            r_own[0] <= i_first_height;
            r_own[1] <= i_first_width;
            r_own[2] <= i_second_height;
            r_own[3] <= i_second_width;

            r_rx[0] <= i_first_axis_x;
            r_ry[0] <= i_first_axis_y;
            r_w[0]  <= i_first_width;
            r_h[0]  <= i_first_height;
            r_rx[1] <= i_second_axis_x;
            r_ry[1] <= i_second_axis_y;
            r_w[1]  <= i_second_width;
            r_h[1]  <= i_second_height;
        end
    end

    // first box's axes test against the second box and vice versa
    for (genvar g = 0; g < NA; g++) begin : g_axis
        localparam int OTH = (g < 2) ? 1 : 0;
        obbsat_axis_unit u_axis (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_dx       (r_dx),
            .i_dy       (r_dy),
            .i_dir_x    (r_dir_x[g]),
            .i_dir_y    (r_dir_y[g]),
            .i_oth_rx   (r_rx[OTH]),
            .i_oth_ry   (r_ry[OTH]),
            .i_oth_w    (r_w[OTH]),
            .i_oth_h    (r_h[OTH]),
            .i_own_size (r_own[g]),
            .o_sep      (w_sep[g])
        );
    end

    // collided when no axis separates; touching counts as collided
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[obbsat_pkg::ST_OUT]) begin
            r_collided <= ~(|w_sep);
        end
    end

    assign o_valid    = w_ctl.vld[obbsat_pkg::ST_OUT];
    assign o_collided = r_collided;

endmodule

### design/obbsat_checker.sv
// Port-level assertions for the OBB SAT unit and their bind.
`include "obb_pair_separating_axis_test_unit_defines.svh"

module obbsat_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_collided
);

    // input is refused only when a result is waiting and held
    `OBBSAT_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // a held result stays put
    `OBBSAT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_collided))

    // a transfer followed by no output stall reaches the output as a valid result
    `OBBSAT_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall, o_valid)

endmodule

bind obb_pair_separating_axis_test_unit obbsat_checker u_obbsat_checker (.*);
